// ----- sv/segment_intersect_gate_macros.svh -----
// Assertion macros for the segment intersection gate.
`ifndef SEGMENT_INTERSECT_GATE_MACROS_SVH
`define SEGMENT_INTERSECT_GATE_MACROS_SVH
`ifndef SYNTH
`define SIG_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
`define SIG_ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) !(expr)) else $error(msg);
`else
`define SIG_ASSERT(label, prop, msg)
`define SIG_ASSERT_NEVER(label, expr, msg)
`endif
`endif

// ----- sv/sig_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package sig_pkg;
    localparam int COORD_BITS = 12;
    localparam int CB   = COORD_BITS;
    localparam int RXW  = 12;
    localparam int RWW  = 13;
    localparam int EW   = 14;
    localparam int DW   = CB + 1;
    localparam int LW   = 2 * CB + 1;
    localparam int DENW = 2 * CB + 2;
    localparam int CAW  = 2 * CB + 1;
    localparam int PNW  = CAW + DW;
    localparam int NW   = PNW + 1;
    localparam int D2W  = 4 * CB + 2;
    localparam int HW   = D2W / 2;
    localparam int KW   = 20;
    localparam int LHW  = D2W + KW;
    localparam int QW   = EW - 1;
    localparam int NNW  = EW + LW + 2;
    localparam int DDW  = LW + 1;
    localparam int CW   = ((NW > EW + LW) ? NW : EW + LW) + 1;
    localparam int XW   = ((CB > QW) ? CB : QW) + 1;

    localparam logic [KW-1:0] COS_DEN2 = KW'(1000000);
    localparam logic [KW-1:0] COS_NUM2 = KW'(499849);

    typedef enum logic [1:0] {
        REG_ROI_X = 2'd0,
        REG_ROI_Y = 2'd1,
        REG_ROI_W = 2'd2,
        REG_ROI_H = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [CB-1:0] a_start_x;
        logic [CB-1:0] a_start_y;
        logic [CB-1:0] a_end_x;
        logic [CB-1:0] a_end_y;
        logic [CB-1:0] b_start_x;
        logic [CB-1:0] b_start_y;
        logic [CB-1:0] b_end_x;
        logic [CB-1:0] b_end_y;
    } seg_pair_t;

    typedef struct packed {
        logic          found;
        logic [CB-1:0] cross_x;
        logic [CB-1:0] cross_y;
    } crossing_t;

    typedef struct packed {
        logic [RXW-1:0] x;
        logic [RXW-1:0] y;
        logic [RWW-1:0] w;
        logic [RWW-1:0] h;
    } roi_t;

    typedef struct packed {
        seg_pair_t     pts;
        logic [LW-1:0] la;
        logic [LW-1:0] lb;
        logic          ok;
    } side_t;

    typedef struct packed {
        logic [NNW-1:0] n_x;
        logic [NNW-1:0] n_y;
        logic [DDW-1:0] d;
        side_t          side;
    } div_in_t;

    typedef struct packed {
        logic [QW-1:0] q_x;
        logic [QW-1:0] q_y;
        side_t         side;
    } div_out_t;
endpackage
`default_nettype wire

// ----- sv/sig_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
module sig_front (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  sig_pkg::roi_t       roi,
    input  wire                 s_valid,
    output logic                s_ready,
    input  sig_pkg::seg_pair_t  s_data,
    output logic                m_valid,
    input  wire                 m_ready,
    output sig_pkg::div_in_t    m_data
);
    import sig_pkg::*;

    localparam int NS = 7;
    localparam int PW = ((CB > EW) ? CB : EW) + 1;

    logic [NS-1:0] v_reg;
    logic [NS:0]   en;

    always_comb begin
        en[NS] = m_ready;
        for (int k = NS - 1; k >= 0; k--) begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (en[0]) begin
                v_reg[0] <= s_valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (en[k]) begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    assign s_ready = en[0];
    assign m_valid = v_reg[NS-1];

    function automatic logic in_rect(logic [CB-1:0] x, logic [CB-1:0] y, roi_t r);
        logic [PW-1:0] xe, ye, x0, y0, x1, y1;
        xe = PW'(x);
        ye = PW'(y);
        x0 = PW'(r.x);
        y0 = PW'(r.y);
        x1 = PW'(r.x) + PW'(r.w);
        y1 = PW'(r.y) + PW'(r.h);
        return (xe >= x0) && (xe < x1) && (ye >= y0) && (ye < y1);
    endfunction

    function automatic logic signed [DW-1:0] sdiff(logic [CB-1:0] a, logic [CB-1:0] b);
        return $signed({1'b0, a}) - $signed({1'b0, b});
    endfunction

    // stage 1: bounds and direction vectors
    seg_pair_t              p1_reg;
    logic [3:0]             ir1_reg;
    logic signed [DW-1:0]   ux1_reg, uy1_reg, vx1_reg, vy1_reg;

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            p1_reg     <= s_data;
            ir1_reg[0] <= in_rect(s_data.a_start_x, s_data.a_start_y, roi);
            ir1_reg[1] <= in_rect(s_data.a_end_x, s_data.a_end_y, roi);
            ir1_reg[2] <= in_rect(s_data.b_start_x, s_data.b_start_y, roi);
            ir1_reg[3] <= in_rect(s_data.b_end_x, s_data.b_end_y, roi);
            ux1_reg    <= sdiff(s_data.a_start_x, s_data.a_end_x);
            uy1_reg    <= sdiff(s_data.a_start_y, s_data.a_end_y);
            vx1_reg    <= sdiff(s_data.b_start_x, s_data.b_end_x);
            vy1_reg    <= sdiff(s_data.b_start_y, s_data.b_end_y);
        end
    end

    // stage 2: products
    seg_pair_t                p2_reg;
    logic [3:0]               ir2_reg;
    logic signed [DW-1:0]     ux2_reg, uy2_reg, vx2_reg, vy2_reg;
    logic signed [2*DW-1:0]   dena2_reg, denb2_reg, laa2_reg, lab2_reg;
    logic signed [2*DW-1:0]   lba2_reg, lbb2_reg, dota2_reg, dotb2_reg;
    logic [2*CB-1:0]          caa2_reg, cab2_reg, cba2_reg, cbb2_reg;

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            p2_reg    <= p1_reg;
            ir2_reg   <= ir1_reg;
            ux2_reg   <= ux1_reg;
            uy2_reg   <= uy1_reg;
            vx2_reg   <= vx1_reg;
            vy2_reg   <= vy1_reg;
            dena2_reg <= ux1_reg * vy1_reg;
            denb2_reg <= uy1_reg * vx1_reg;
            laa2_reg  <= ux1_reg * ux1_reg;
            lab2_reg  <= uy1_reg * uy1_reg;
            lba2_reg  <= vx1_reg * vx1_reg;
            lbb2_reg  <= vy1_reg * vy1_reg;
            dota2_reg <= ux1_reg * vx1_reg;
            dotb2_reg <= uy1_reg * vy1_reg;
            caa2_reg  <= p1_reg.a_start_x * p1_reg.a_end_y;
            cab2_reg  <= p1_reg.a_start_y * p1_reg.a_end_x;
            cba2_reg  <= p1_reg.b_start_x * p1_reg.b_end_y;
            cbb2_reg  <= p1_reg.b_start_y * p1_reg.b_end_x;
        end
    end

    // stage 3: sums
    seg_pair_t               p3_reg;
    logic                    rect3_reg;
    logic signed [DW-1:0]    ux3_reg, uy3_reg, vx3_reg, vy3_reg;
    logic signed [DENW-1:0]  den3_reg, dot3_reg;
    logic signed [CAW-1:0]   ca3_reg, cb3_reg;
    logic [LW-1:0]           la3_reg, lb3_reg;

    always_ff @(posedge aclk) begin
        if (en[2]) begin
            p3_reg    <= p2_reg;
            rect3_reg <= &ir2_reg;
            ux3_reg   <= ux2_reg;
            uy3_reg   <= uy2_reg;
            vx3_reg   <= vx2_reg;
            vy3_reg   <= vy2_reg;
            den3_reg  <= dena2_reg - denb2_reg;
            dot3_reg  <= dota2_reg + dotb2_reg;
            ca3_reg   <= $signed({1'b0, caa2_reg}) - $signed({1'b0, cab2_reg});
            cb3_reg   <= $signed({1'b0, cba2_reg}) - $signed({1'b0, cbb2_reg});
            la3_reg   <= LW'(laa2_reg + lab2_reg);
            lb3_reg   <= LW'(lba2_reg + lbb2_reg);
        end
    end

    // stage 4: numerator products, cosine squares
    seg_pair_t               p4_reg;
    logic                    rect4_reg, dneg4_reg;
    logic signed [DENW-1:0]  den4_reg;
    logic signed [PNW-1:0]   nxa4_reg, nxb4_reg, nya4_reg, nyb4_reg;
    logic [D2W-1:0]          d2_4_reg, ll4_reg;
    logic [LW-1:0]           la4_reg, lb4_reg;

    always_ff @(posedge aclk) begin
        if (en[3]) begin
            p4_reg    <= p3_reg;
            rect4_reg <= rect3_reg;
            dneg4_reg <= dot3_reg[DENW-1];
            den4_reg  <= den3_reg;
            nxa4_reg  <= ca3_reg * vx3_reg;
            nxb4_reg  <= ux3_reg * cb3_reg;
            nya4_reg  <= ca3_reg * vy3_reg;
            nyb4_reg  <= uy3_reg * cb3_reg;
            d2_4_reg  <= D2W'(dot3_reg * dot3_reg);
            ll4_reg   <= la3_reg * lb3_reg;
            la4_reg   <= la3_reg;
            lb4_reg   <= lb3_reg;
        end
    end

    // stage 5: numerators with sign fix, cosine partial products
    logic signed [NW-1:0] nx_c, ny_c;
    logic                 dsign;

    always_comb begin
        dsign = den4_reg[DENW-1];
        nx_c  = NW'(nxa4_reg) - NW'(nxb4_reg);
        ny_c  = NW'(nya4_reg) - NW'(nyb4_reg);
        if (dsign) begin
            nx_c = -nx_c;
            ny_c = -ny_c;
        end
    end

    seg_pair_t             p5_reg;
    logic                  rect5_reg, dneg5_reg, dz5_reg;
    logic signed [NW-1:0]  nx5_reg, ny5_reg;
    logic [LW-1:0]         dmag5_reg, la5_reg, lb5_reg;
    logic [HW+KW-1:0]      lhsl5_reg, lhsh5_reg, rhsl5_reg, rhsh5_reg;

    always_ff @(posedge aclk) begin
        if (en[4]) begin
            p5_reg    <= p4_reg;
            rect5_reg <= rect4_reg;
            dneg5_reg <= dneg4_reg;
            dz5_reg   <= (den4_reg == '0);
            nx5_reg   <= nx_c;
            ny5_reg   <= ny_c;
            dmag5_reg <= dsign ? LW'(-den4_reg) : LW'(den4_reg);
            la5_reg   <= la4_reg;
            lb5_reg   <= lb4_reg;
            lhsl5_reg <= d2_4_reg[HW-1:0] * COS_DEN2;
            lhsh5_reg <= d2_4_reg[D2W-1:HW] * COS_DEN2;
            rhsl5_reg <= ll4_reg[HW-1:0] * COS_NUM2;
            rhsh5_reg <= ll4_reg[D2W-1:HW] * COS_NUM2;
        end
    end

    // stage 6: rectangle edges scaled by den, cosine sums
    logic [EW-1:0] ex_c, ey_c;

    assign ex_c = EW'(roi.x) + EW'(roi.w);
    assign ey_c = EW'(roi.y) + EW'(roi.h);

    seg_pair_t             p6_reg;
    logic                  rect6_reg, dneg6_reg, dz6_reg;
    logic signed [NW-1:0]  nx6_reg, ny6_reg;
    logic [LW-1:0]         dmag6_reg, la6_reg, lb6_reg;
    logic [EW+LW-1:0]      lox6_reg, hix6_reg, loy6_reg, hiy6_reg;
    logic [LHW-1:0]        lhs6_reg, rhs6_reg;

    always_ff @(posedge aclk) begin
        if (en[5]) begin
            p6_reg    <= p5_reg;
            rect6_reg <= rect5_reg;
            dneg6_reg <= dneg5_reg;
            dz6_reg   <= dz5_reg;
            nx6_reg   <= nx5_reg;
            ny6_reg   <= ny5_reg;
            dmag6_reg <= dmag5_reg;
            la6_reg   <= la5_reg;
            lb6_reg   <= lb5_reg;
            lox6_reg  <= EW'(roi.x) * dmag5_reg;
            hix6_reg  <= ex_c * dmag5_reg;
            loy6_reg  <= EW'(roi.y) * dmag5_reg;
            hiy6_reg  <= ey_c * dmag5_reg;
            lhs6_reg  <= (LHW'(lhsh5_reg) << HW) + LHW'(lhsl5_reg);
            rhs6_reg  <= (LHW'(rhsh5_reg) << HW) + LHW'(rhsl5_reg);
        end
    end

    // stage 7: decisions, dividend and divisor
    logic signed [CW-1:0] nxw, nyw;
    logic                 in_box, cos_ok, ok;
    div_in_t              out_next;
    div_in_t              out_reg;

    always_comb begin
        nxw    = CW'(nx6_reg);
        nyw    = CW'(ny6_reg);
        in_box = (nxw >= $signed(CW'(lox6_reg))) && (nxw < $signed(CW'(hix6_reg))) &&
                 (nyw >= $signed(CW'(loy6_reg))) && (nyw < $signed(CW'(hiy6_reg)));
        cos_ok = dneg6_reg || (lhs6_reg < rhs6_reg);
        ok     = rect6_reg && !dz6_reg && in_box && cos_ok;
        out_next.n_x     = ok ? (NNW'(nx6_reg) << 1) + NNW'(dmag6_reg) : '0;
        out_next.n_y     = ok ? (NNW'(ny6_reg) << 1) + NNW'(dmag6_reg) : '0;
        out_next.d       = {dmag6_reg, 1'b0};
        out_next.side.pts = p6_reg;
        out_next.side.la  = la6_reg;
        out_next.side.lb  = lb6_reg;
        out_next.side.ok  = ok;
    end

    always_ff @(posedge aclk) begin
        if (en[6]) begin
            out_reg <= out_next;
        end
    end

    assign m_data = out_reg;
endmodule
`default_nettype wire

// ----- sv/sig_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
module sig_div (
    input  wire                aclk,
    input  wire                aresetn,
    input  wire                s_valid,
    output logic               s_ready,
    input  sig_pkg::div_in_t   s_data,
    output logic               m_valid,
    input  wire                m_ready,
    output sig_pkg::div_out_t  m_data
);
    import sig_pkg::*;

    localparam int NS = QW;
    localparam int TW = DDW + QW - 1;
    localparam int MW = (NNW > TW) ? NNW : TW;

    logic [NS-1:0] v_reg;
    logic [NS:0]   en;

    always_comb begin
        en[NS] = m_ready;
        for (int k = NS - 1; k >= 0; k--) begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (en[0]) begin
                v_reg[0] <= s_valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (en[k]) begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    assign s_ready = en[0];
    assign m_valid = v_reg[NS-1];

    logic [NNW-1:0] remx_reg [NS];
    logic [NNW-1:0] remy_reg [NS];
    logic [QW-1:0]  qx_reg   [NS];
    logic [QW-1:0]  qy_reg   [NS];
    logic [DDW-1:0] d_reg    [NS];
    side_t          side_reg [NS];

    // one quotient bit per stage, most significant first
    for (genvar k = 0; k < NS; k++) begin : g_stage
        localparam int SH = QW - 1 - k;
        logic [NNW-1:0] rx_in, ry_in, rx_next, ry_next;
        logic [QW-1:0]  qx_in, qy_in, qx_next, qy_next;
        logic [DDW-1:0] d_in;
        side_t          s_in;
        logic [MW-1:0]  trial;

        if (k == 0) begin : g_first
            assign rx_in = s_data.n_x;
            assign ry_in = s_data.n_y;
            assign qx_in = '0;
            assign qy_in = '0;
            assign d_in  = s_data.d;
            assign s_in  = s_data.side;
        end else begin : g_next
            assign rx_in = remx_reg[k-1];
            assign ry_in = remy_reg[k-1];
            assign qx_in = qx_reg[k-1];
            assign qy_in = qy_reg[k-1];
            assign d_in  = d_reg[k-1];
            assign s_in  = side_reg[k-1];
        end

        always_comb begin
            trial   = MW'(d_in) << SH;
            rx_next = rx_in;
            ry_next = ry_in;
            qx_next = qx_in;
            qy_next = qy_in;
            if (MW'(rx_in) >= trial) begin
                rx_next = NNW'(MW'(rx_in) - trial);
                qx_next = qx_in | (QW'(1) << SH);
            end
            if (MW'(ry_in) >= trial) begin
                ry_next = NNW'(MW'(ry_in) - trial);
                qy_next = qy_in | (QW'(1) << SH);
            end
        end

        always_ff @(posedge aclk) begin
            if (en[k]) begin
                remx_reg[k] <= rx_next;
                remy_reg[k] <= ry_next;
                qx_reg[k]   <= qx_next;
                qy_reg[k]   <= qy_next;
                d_reg[k]    <= d_in;
                side_reg[k] <= s_in;
            end
        end
    end

    assign m_data.q_x  = qx_reg[NS-1];
    assign m_data.q_y  = qy_reg[NS-1];
    assign m_data.side = side_reg[NS-1];
endmodule
`default_nettype wire

// ----- sv/sig_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
module sig_back (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_valid,
    output logic                s_ready,
    input  sig_pkg::div_out_t   s_data,
    output logic                m_valid,
    input  wire                 m_ready,
    output sig_pkg::crossing_t  m_data
);
    import sig_pkg::*;

    localparam int NS  = 4;
    localparam int SQW = 2 * XW;
    localparam int SDW = 2 * XW + 1;
    localparam int CMW = ((SDW + 2 > LW) ? SDW + 2 : LW) + 1;

    logic [NS-1:0] v_reg;
    logic [NS:0]   en;

    always_comb begin
        en[NS] = m_ready;
        for (int k = NS - 1; k >= 0; k--) begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (en[0]) begin
                v_reg[0] <= s_valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (en[k]) begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    assign s_ready = en[0];
    assign m_valid = v_reg[NS-1];

    logic [CB-1:0] crd [8];
    logic [QW-1:0] rnd [8];

    always_comb begin
        crd[0] = s_data.side.pts.a_start_x;
        crd[1] = s_data.side.pts.a_start_y;
        crd[2] = s_data.side.pts.a_end_x;
        crd[3] = s_data.side.pts.a_end_y;
        crd[4] = s_data.side.pts.b_start_x;
        crd[5] = s_data.side.pts.b_start_y;
        crd[6] = s_data.side.pts.b_end_x;
        crd[7] = s_data.side.pts.b_end_y;
        for (int i = 0; i < 8; i++) begin
            rnd[i] = (i % 2 == 0) ? s_data.q_x : s_data.q_y;
        end
    end

    // stage 1: offsets from the rounded crossing
    logic signed [XW-1:0] dif1_reg [8];
    logic                 ok1_reg;
    logic [LW-1:0]        la1_reg, lb1_reg;
    logic [QW-1:0]        qx1_reg, qy1_reg;

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            for (int i = 0; i < 8; i++) begin
                dif1_reg[i] <= $signed(XW'(crd[i])) - $signed(XW'(rnd[i]));
            end
            ok1_reg <= s_data.side.ok &&
                       (XW'(s_data.q_x) <= XW'((1 << CB) - 1)) &&
                       (XW'(s_data.q_y) <= XW'((1 << CB) - 1));
            la1_reg <= s_data.side.la;
            lb1_reg <= s_data.side.lb;
            qx1_reg <= s_data.q_x;
            qy1_reg <= s_data.q_y;
        end
    end

    // stage 2: squares
    logic [SQW-1:0]  sq2_reg [8];
    logic            ok2_reg;
    logic [LW-1:0]   la2_reg, lb2_reg;
    logic [QW-1:0]   qx2_reg, qy2_reg;

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            for (int i = 0; i < 8; i++) begin
                sq2_reg[i] <= SQW'(dif1_reg[i]) * SQW'(dif1_reg[i]);
            end
            ok2_reg <= ok1_reg;
            la2_reg <= la1_reg;
            lb2_reg <= lb1_reg;
            qx2_reg <= qx1_reg;
            qy2_reg <= qy1_reg;
        end
    end

    // stage 3: squared distances to the four end points
    logic [SDW-1:0] dst3_reg [4];
    logic           ok3_reg;
    logic [LW-1:0]  la3_reg, lb3_reg;
    logic [QW-1:0]  qx3_reg, qy3_reg;

    always_ff @(posedge aclk) begin
        if (en[2]) begin
            for (int i = 0; i < 4; i++) begin
                dst3_reg[i] <= SDW'(sq2_reg[2*i]) + SDW'(sq2_reg[2*i+1]);
            end
            ok3_reg <= ok2_reg;
            la3_reg <= la2_reg;
            lb3_reg <= lb2_reg;
            qx3_reg <= qx2_reg;
            qy3_reg <= qy2_reg;
        end
    end

    // stage 4: nearer end point test, result register
    logic [SDW-1:0] da, db;
    logic           good;
    crossing_t      out_next;
    crossing_t      out_reg;

    always_comb begin
        da   = (dst3_reg[1] < dst3_reg[0]) ? dst3_reg[1] : dst3_reg[0];
        db   = (dst3_reg[3] < dst3_reg[2]) ? dst3_reg[3] : dst3_reg[2];
        good = ok3_reg &&
               ((CMW'(da) << 2) < CMW'(la3_reg)) &&
               ((CMW'(db) << 2) < CMW'(lb3_reg));
        out_next.found   = good;
        out_next.cross_x = good ? CB'(qx3_reg) : '0;
        out_next.cross_y = good ? CB'(qy3_reg) : '0;
    end

    always_ff @(posedge aclk) begin
        if (en[3]) begin
            out_reg <= out_next;
        end
    end

    assign m_data = out_reg;
endmodule
`default_nettype wire

// ----- sv/segment_intersect_gate.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "segment_intersect_gate_macros.svh"
// Segment intersection gate: takes one segment pair per clock while s_ready is high and returns
// one crossing transaction per pair, in order. The pipeline has 7 front stages (products,
// rectangle and cosine tests), a 13-stage divider that rounds the crossing one quotient bit
// per stage, and 4 stages of end point distance tests ending in the output register. Every
// stage holds a valid bit, so bubbles fill in while the output waits. Rectangle registers are
// written through the cfg port, always ready, and must only be changed while no transaction
// is in flight.
module segment_intersect_gate (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_valid,
    output logic                s_ready,
    input  sig_pkg::seg_pair_t  s_data,
    output logic                m_valid,
    input  wire                 m_ready,
    output sig_pkg::crossing_t  m_data,
    input  wire                 cfg_valid,
    output logic                cfg_ready,
    input  wire [1:0]           cfg_index,
    input  wire [12:0]          cfg_data
);
    import sig_pkg::*;

    roi_t roi_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            roi_reg.x <= RXW'(10);
            roi_reg.y <= RXW'(10);
            roi_reg.w <= RWW'(4086);
            roi_reg.h <= RWW'(4086);
        end else if (cfg_valid && cfg_ready) begin
            unique case (reg_idx_t'(cfg_index))
                REG_ROI_X: begin
                    roi_reg.x <= cfg_data[RXW-1:0];
                end
                REG_ROI_Y: begin
                    roi_reg.y <= cfg_data[RXW-1:0];
                end
                REG_ROI_W: begin
                    roi_reg.w <= cfg_data[RWW-1:0];
                end
                REG_ROI_H: begin
                    roi_reg.h <= cfg_data[RWW-1:0];
                end
                default: begin
                    roi_reg <= roi_reg;
                end
            endcase
        end
    end

    logic     fd_valid, fd_ready, db_valid, db_ready;
    div_in_t  fd_data;
    div_out_t db_data;

    sig_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .roi     (roi_reg),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (fd_valid),
        .m_ready (fd_ready),
        .m_data  (fd_data)
    );

    sig_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (fd_valid),
        .s_ready (fd_ready),
        .s_data  (fd_data),
        .m_valid (db_valid),
        .m_ready (db_ready),
        .m_data  (db_data)
    );

    sig_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (db_valid),
        .s_ready (db_ready),
        .s_data  (db_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    `SIG_ASSERT(a_reject_zero, m_valid |-> (m_data.found || (m_data.cross_x == '0 && m_data.cross_y == '0)), "rejected transaction carries nonzero crossing")
    `SIG_ASSERT(a_full_stall, !s_ready |-> (m_valid && !m_ready), "input stalled while pipeline can move")
    `SIG_ASSERT(a_cfg_x, (cfg_valid && cfg_ready && cfg_index == REG_ROI_X) |=> (roi_reg.x == $past(cfg_data[RXW-1:0])), "roi_x write lost")
    `SIG_ASSERT_NEVER(a_mid_stall, db_valid && !db_ready && !(m_valid && !m_ready), "back end stalled without output stall")
endmodule
`default_nettype wire

// ----- tb/crossing_checker.sv -----
`timescale 1ns / 1ps
module crossing_checker (
    input  wire                aclk,
    input  wire                aresetn,
    input  wire                s_valid,
    input  wire                s_ready,
    input  sig_pkg::seg_pair_t s_data,
    input  wire                m_valid,
    input  wire                m_ready,
    input  sig_pkg::crossing_t m_data,
    input  wire                cfg_valid,
    input  wire                cfg_ready,
    input  wire [1:0]          cfg_index,
    input  wire [12:0]         cfg_data,
    output int                 fail_count,
    output int                 pending
);
    import sig_pkg::*;

    logic [11:0] rect_x, rect_y;
    logic [12:0] rect_w, rect_h;
    crossing_t   crossing_q[$];

    function automatic bit pt_inside(longint x, longint y);
        return x >= longint'(rect_x) && x < longint'(rect_x) + longint'(rect_w)
            && y >= longint'(rect_y) && y < longint'(rect_y) + longint'(rect_h);
    endfunction

    function automatic longint dist2(longint ax, longint ay, longint bx, longint by);
        return (ax - bx) * (ax - bx) + (ay - by) * (ay - by);
    endfunction

    function automatic crossing_t crossing_of(seg_pair_t p);
        longint x1, y1, x2, y2, x3, y3, x4, y4;
        longint ux, uy, vx, vy, den, ca, cb, nx, ny, rx, ry, la, lb, da, db, dot;
        logic [127:0] lhs, rhs;
        crossing_t r;
        r = '0;
        x1 = longint'(p.a_start_x); y1 = longint'(p.a_start_y);
        x2 = longint'(p.a_end_x);   y2 = longint'(p.a_end_y);
        x3 = longint'(p.b_start_x); y3 = longint'(p.b_start_y);
        x4 = longint'(p.b_end_x);   y4 = longint'(p.b_end_y);
        if (!pt_inside(x1, y1) || !pt_inside(x2, y2) || !pt_inside(x3, y3)
            || !pt_inside(x4, y4)) return r;
        ux = x1 - x2; uy = y1 - y2; vx = x3 - x4; vy = y3 - y4;
        den = ux * vy - uy * vx;
        if (den == 0) return r;
        ca = x1 * y2 - y1 * x2;
        cb = x3 * y4 - y3 * x4;
        nx = ca * vx - ux * cb;
        ny = ca * vy - uy * cb;
        if (den < 0) begin
            den = -den; nx = -nx; ny = -ny;
        end
        if (nx < longint'(rect_x) * den || nx >= (longint'(rect_x) + longint'(rect_w)) * den
            || ny < longint'(rect_y) * den
            || ny >= (longint'(rect_y) + longint'(rect_h)) * den)
            return r;
        rx = (2 * nx + den) / (2 * den);
        ry = (2 * ny + den) / (2 * den);
        if (rx > 4095 || ry > 4095) return r;
        la = ux * ux + uy * uy;
        lb = vx * vx + vy * vy;
        da = dist2(x1, y1, rx, ry);
        if (dist2(x2, y2, rx, ry) < da) da = dist2(x2, y2, rx, ry);
        db = dist2(x3, y3, rx, ry);
        if (dist2(x4, y4, rx, ry) < db) db = dist2(x4, y4, rx, ry);
        if (!(4 * da < la && 4 * db < lb)) return r;
        dot = ux * vx + uy * vy;
        if (dot >= 0) begin
            lhs = 128'(dot) * 128'(dot) * 128'(1000000);
            rhs = 128'(la) * 128'(lb) * 128'(499849);
            if (!(lhs < rhs)) return r;
        end
        r.found = 1'b1;
        r.cross_x = rx[11:0];
        r.cross_y = ry[11:0];
        return r;
    endfunction

    assign pending = crossing_q.size();

    always @(posedge aclk) begin
        crossing_t want;
        if (!aresetn) begin
            rect_x <= 12'd10; rect_y <= 12'd10; rect_w <= 13'd4086; rect_h <= 13'd4086;
            fail_count <= 0;
            crossing_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (reg_idx_t'(cfg_index))
                    REG_ROI_X: rect_x <= cfg_data[11:0];
                    REG_ROI_Y: rect_y <= cfg_data[11:0];
                    REG_ROI_W: rect_w <= cfg_data;
                    REG_ROI_H: rect_h <= cfg_data;
                endcase
            end
            if (s_valid && s_ready) crossing_q = {crossing_q, crossing_of(s_data)};
            if (m_valid && m_ready) begin
                if (crossing_q.size() == 0) begin
                    if (fail_count < 10) $display("unexpected transaction %h", m_data);
                    fail_count <= fail_count + 1;
                end else begin
                    want = crossing_q.pop_front();
                    if (want.found !== m_data.found || want.cross_x !== m_data.cross_x
                        || want.cross_y !== m_data.cross_y) begin
                        if (fail_count < 10)
                            $display("mismatch: expected %b %0d %0d, got %b %0d %0d",
                                want.found, want.cross_x, want.cross_y,
                                m_data.found, m_data.cross_x, m_data.cross_y);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
module testbench;
    import sig_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    seg_pair_t   s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    crossing_t   m_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [12:0] cfg_data = '0;
    int          fail_count, pending;
    int          cycle_count = 0;
    bit          calm = 1'b0;
    bit          hold_off = 1'b0;
    logic [11:0] box_x = 12'd10, box_y = 12'd10;
    logic [12:0] box_w = 13'd4086, box_h = 13'd4086;

    always #1 aclk = ~aclk;

    segment_intersect_gate uut (.*);

    crossing_checker check (.*);

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000) begin
            $display("status: fail");
            $finish;
        end
    end

    always @(negedge aclk) begin
        if (hold_off) m_ready <= 1'b0;
        else m_ready <= calm || ($urandom_range(99) >= 17);
    end

    task automatic write_reg(reg_idx_t idx, logic [12:0] value);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_box(logic [11:0] x, logic [11:0] y, logic [12:0] w, logic [12:0] h);
        while (pending != 0) @(negedge aclk);
        repeat (30) @(negedge aclk);
        box_x = x; box_y = y; box_w = w; box_h = h;
        write_reg(REG_ROI_X, {1'b0, x});
        write_reg(REG_ROI_Y, {1'b0, y});
        write_reg(REG_ROI_W, w);
        write_reg(REG_ROI_H, h);
    endtask

    task automatic offer(seg_pair_t p);
        while (!calm && $urandom_range(99) < 17) @(negedge aclk);
        s_valid = 1'b1;
        s_data = p;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    function automatic logic [11:0] in_span(logic [11:0] lo, logic [12:0] w);
        int hi;
        hi = lo + w - 1;
        if (w == 0 || $urandom_range(19) == 0) return 12'($urandom);
        if (hi > 4095) hi = 4095;
        return 12'($urandom_range(hi, lo));
    endfunction

    function automatic seg_pair_t box_pair();
        seg_pair_t p;
        p.a_start_x = in_span(box_x, box_w); p.a_start_y = in_span(box_y, box_h);
        p.a_end_x = in_span(box_x, box_w);   p.a_end_y = in_span(box_y, box_h);
        p.b_start_x = in_span(box_x, box_w); p.b_start_y = in_span(box_y, box_h);
        p.b_end_x = in_span(box_x, box_w);   p.b_end_y = in_span(box_y, box_h);
        return p;
    endfunction

    // crossing pair: two segments through a common point, likely to pass every test
    function automatic seg_pair_t crossing_pair();
        seg_pair_t p;
        int cx, cy, ax, ay, bx, by;
        cx = $urandom_range(3800, 300); cy = $urandom_range(3800, 300);
        ax = $urandom_range(250, 1); ay = $urandom_range(250, 0);
        bx = -int'($urandom_range(250, 0)); by = $urandom_range(250, 1);
        p.a_start_x = 12'(cx + ax); p.a_start_y = 12'(cy + ay);
        p.a_end_x = 12'(cx - ax - int'($urandom_range(3))); p.a_end_y = 12'(cy - ay);
        p.b_start_x = 12'(cx + bx); p.b_start_y = 12'(cy + by);
        p.b_end_x = 12'(cx - bx); p.b_end_y = 12'(cy - by + int'($urandom_range(3)));
        return p;
    endfunction

    initial begin
        seg_pair_t p;
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        offer('0);
        offer('1);
        offer({12'd10, 12'd10, 12'd4095, 12'd4095, 12'd10, 12'd4095, 12'd4095, 12'd10});
        offer({12'd100, 12'd100, 12'd100, 12'd100, 12'd200, 12'd100, 12'd300, 12'd300});
        offer({12'd100, 12'd100, 12'd300, 12'd100, 12'd100, 12'd200, 12'd300, 12'd200});
        offer({12'd100, 12'd100, 12'd300, 12'd300, 12'd100, 12'd300, 12'd300, 12'd100});
        offer({12'd100, 12'd100, 12'd301, 12'd300, 12'd100, 12'd300, 12'd300, 12'd101});
        offer({12'd100, 12'd100, 12'd300, 12'd120, 12'd100, 12'd110, 12'd300, 12'd100});
        offer({12'd100, 12'd100, 12'd110, 12'd100, 12'd200, 12'd50, 12'd200, 12'd300});
        offer({12'd4000, 12'd4000, 12'd4090, 12'd4094, 12'd4000, 12'd4094, 12'd4094, 12'd3990});
        offer({12'd9, 12'd100, 12'd300, 12'd300, 12'd100, 12'd300, 12'd300, 12'd100});
        set_box(12'd0, 12'd0, 13'd4096, 13'd4096);
        offer({12'd0, 12'd0, 12'd4095, 12'd4095, 12'd0, 12'd4095, 12'd4095, 12'd0});
        offer({12'd4094, 12'd4095, 12'd4095, 12'd4094, 12'd4095, 12'd4095, 12'd4094, 12'd4094});
        set_box(12'd4095, 12'd4095, 13'd0, 13'd0);
        offer({12'd100, 12'd100, 12'd300, 12'd300, 12'd100, 12'd300, 12'd300, 12'd100});
        set_box(12'd200, 12'd200, 13'd400, 13'd400);
        offer({12'd200, 12'd200, 12'd599, 12'd599, 12'd200, 12'd599, 12'd599, 12'd200});
        offer({12'd200, 12'd200, 12'd210, 12'd220, 12'd200, 12'd220, 12'd220, 12'd200});

        // fill the pipeline while the output is stalled
        hold_off = 1'b1;
        fork
            begin
                int n;
                for (n = 0; n < 60; n++) @(posedge aclk);
                hold_off = 1'b0;
            end
            for (int k = 0; k < 40; k++) offer(box_pair());
        join

        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: set_box(12'd10, 12'd10, 13'd4086, 13'd4086);
                1: set_box(12'd0, 12'd0, 13'd4096, 13'd4096);
                2: set_box(12'd1000, 12'd500, 13'd2000, 13'd3000);
                3: set_box(12'd3000, 12'd3000, 13'd4096, 13'd4096);
                default: set_box(12'($urandom), 12'($urandom), 13'($urandom_range(4096)),
                                  13'($urandom_range(4096)));
            endcase
            calm = (phase == 1);
            for (int k = 0; k < 130; k++) begin
                if ($urandom_range(9) < 6) p = crossing_pair();
                else if ($urandom_range(1)) p = box_pair();
                else p = seg_pair_t'({$urandom, $urandom, $urandom});
                offer(p);
            end
            calm = 1'b0;
        end

        while (pending != 0) @(negedge aclk);
        repeat (40) @(negedge aclk);
        if (fail_count == 0) $display("status: pass");
        else $display("status: fail");
        $finish;
    end
endmodule
